// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl file buzzer_pattern_sequencer.sv
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/bps_pkg.sv =====
// types, codes and the segment rom of the buzzer pattern sequencer
// no dependencies
package bps_pkg;

   localparam int TICKS_PER_MS = 10;
   localparam int SEG_TICKS_W  = 13;
   localparam int SEG_MS_W     = 10;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_PLAY = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;

   localparam logic [2:0] PAT_NONE   = 3'd0;
   localparam logic [2:0] PAT_SHORT  = 3'd1;
   localparam logic [2:0] PAT_DOUBLE = 3'd2;
   localparam logic [2:0] PAT_TRIPLE = 3'd3;
   localparam logic [2:0] PAT_LONG   = 3'd4;
   localparam logic [2:0] PAT_ALARM  = 3'd5;

   typedef struct packed {
      logic                   tone;
      logic [SEG_MS_W-1:0]    ms;
      logic [2:0]             half;
   } seg_row_type;

   typedef struct packed {
      logic                   playing;
      logic [2:0]             active_pattern;
      logic [3:0]             segment_index;
      logic                   segment_is_tone;
      logic [SEG_TICKS_W-1:0] segment_ticks_left;
      logic [2:0]             half_period;
      logic [2:0]             half_ticks_left;
      logic                   wave_level;
   } state_type;

   // zero duration marks the end of a sequence; unused slots read as that
   function automatic seg_row_type seg_rom(input logic [2:0] pat, input logic [3:0] idx);
      seg_row_type row;
      row = '0;
      unique case (pat)
         PAT_SHORT: begin
            unique case (idx)
               4'd0:    row = '{1'b1, 10'd160, 3'd5};
               4'd1:    row = '{1'b0, 10'd150, 3'd0};
               default: row = '0;
            endcase
         end
         PAT_DOUBLE: begin
            unique case (idx)
               4'd0, 4'd2: row = '{1'b1, 10'd130, 3'd3};
               4'd1, 4'd3: row = '{1'b0, 10'd120, 3'd0};
               default:    row = '0;
            endcase
         end
         PAT_TRIPLE: begin
            unique case (idx)
               4'd0, 4'd2, 4'd4: row = '{1'b1, 10'd90, 3'd2};
               4'd1, 4'd3, 4'd5: row = '{1'b0, 10'd90, 3'd0};
               default:          row = '0;
            endcase
         end
         PAT_LONG: begin
            unique case (idx)
               4'd0:    row = '{1'b1, 10'd650, 3'd5};
               4'd1:    row = '{1'b0, 10'd200, 3'd0};
               default: row = '0;
            endcase
         end
         PAT_ALARM: begin
            unique case (idx)
               4'd0, 4'd2, 4'd4, 4'd6: row = '{1'b1, 10'd120, 3'd2};
               4'd1, 4'd3, 4'd5, 4'd7: row = '{1'b1, 10'd120, 3'd5};
               4'd8:                   row = '{1'b0, 10'd200, 3'd0};
               default:                row = '0;
            endcase
         end
         default: row = '0;
      endcase
      return row;
   endfunction

endpackage

// ===== rtl/buzzer_pattern_sequencer.sv =====
// buzzer pattern sequencer top level: handshake, state and result registers
// depends on bps_pkg, bps_step and assert_macros.svh
//
// usage:
//   req channel carries one item: operation (tick of 100us, play, stop) and
//   a pattern code for play. rsp channel returns one item per request with
//   the pin level after that item, busy flag and the pattern now playing.
//   csr channel writes active_level (pin polarity); csr_ready is always high.
//   the result is registered and appears in the cycle after the item is accepted.
//   throughput: one item per cycle while req_stall is low; the whole update is one pass through
//   the next-state logic and one segment rom lookup between registers.
//   the single result register frees up in the same cycle it is taken, so
//   req_stall is high only while a result waits and rsp_stall is high.
//   reset: idle, no pattern, no result pending, active_level = 1.
//   stall on rsp holds the result and stalls req; no item is lost.
`include "assert_macros.svh"
module buzzer_pattern_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_pattern,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_pin_level,
   output logic       rsp_busy_res,
   output logic [2:0] rsp_current_pattern,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_active_level
);
   import bps_pkg::*;

   state_type  state_ff, state_in;
   logic       active_level_ff, active_level_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       pin_ff, pin_in;
   logic       busy_ff, busy_in;
   logic [2:0] pattern_ff, pattern_in;
   state_type  step_state;
   logic       req_take;

   bps_step u_step (
      .cur_state (state_ff),
      .operation (req_operation),
      .pattern   (req_pattern),
      .nxt_state (step_state)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in        = req_take ? step_state : state_ff;
      active_level_in = (csr_valid && csr_ready) ? csr_active_level : active_level_ff;
      rsp_valid_in    = req_take | (rsp_valid_ff & rsp_stall);
      pin_in          = pin_ff;
      busy_in         = busy_ff;
      pattern_in      = pattern_ff;
      if (req_take) begin
         pin_in     = step_state.wave_level ? active_level_ff : ~active_level_ff;
         busy_in    = step_state.playing;
         pattern_in = step_state.active_pattern;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '0;
         active_level_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_level_ff <= active_level_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_ff     <= pin_in;
      busy_ff    <= busy_in;
      pattern_ff <= pattern_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pin_level       = pin_ff;
   assign rsp_busy_res        = busy_ff;
   assign rsp_current_pattern = pattern_ff;

   // playing and a nonzero pattern always go together
   `ASSERT_NEVER(a_play_pattern, clock, reset,
      state_ff.playing != (state_ff.active_pattern != PAT_NONE))
   // idle leaves the wave low so the pin sits at the inactive level
   `ASSERT_NEVER(a_idle_wave, clock, reset, !state_ff.playing && state_ff.wave_level)
   // an accepted item always yields a result in the next cycle
   `ASSERT_PROP(a_take_result, clock, reset, req_take |=> rsp_valid_ff)
   // the reported busy flag matches the reported pattern
   `ASSERT_NEVER(a_rsp_busy, clock, reset,
      rsp_valid_ff && (busy_ff != (pattern_ff != PAT_NONE)))
   // a waiting result is never overwritten
   `ASSERT_PROP(a_rsp_hold, clock, reset,
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(pattern_ff) && $stable(pin_ff))

endmodule

// ===== rtl/bps_step.sv =====
// next-state logic of the sequencer for one item: tick, play or stop
// depends on bps_pkg for the state type, codes and segment rom
module bps_step (
   input  bps_pkg::state_type cur_state,
   input  logic [1:0]         operation,
   input  logic [2:0]         pattern,
   output bps_pkg::state_type nxt_state
);
   import bps_pkg::*;

   state_type   pre;
   logic        enter_req;
   seg_row_type row;
   logic [SEG_TICKS_W-1:0] seg_left;
   logic [2:0]             half_left;

   // first pass: counters and command, decides whether a new segment is loaded
   always_comb begin
      pre       = cur_state;
      enter_req = 1'b0;
      seg_left  = '0;
      half_left = '0;
      unique case (operation)
         OP_TICK: begin
            if (cur_state.playing) begin
               if (cur_state.segment_is_tone) begin
                  half_left = (cur_state.half_ticks_left != '0) ?
                              cur_state.half_ticks_left - 3'd1 : '0;
                  if (half_left == '0) begin
                     pre.wave_level      = ~cur_state.wave_level;
                     pre.half_ticks_left = cur_state.half_period;
                  end else begin
                     pre.half_ticks_left = half_left;
                  end
               end
               seg_left = (cur_state.segment_ticks_left != '0) ?
                          cur_state.segment_ticks_left - 1'b1 : '0;
               pre.segment_ticks_left = seg_left;
               if (seg_left == '0) begin
                  pre.segment_index = cur_state.segment_index + 4'd1;
                  enter_req         = 1'b1;
               end
            end
         end
         OP_PLAY: begin
            if (pattern >= PAT_SHORT && pattern <= PAT_ALARM) begin
               pre.playing        = 1'b1;
               pre.active_pattern = pattern;
               pre.segment_index  = '0;
               enter_req          = 1'b1;
            end else begin
               pre = '0;
            end
         end
         OP_STOP: pre = '0;
         default: pre = cur_state;
      endcase
   end

   assign row = seg_rom(pre.active_pattern, pre.segment_index);

   // second pass: load the segment, or go idle on a terminator
   always_comb begin
      nxt_state = pre;
      if (enter_req) begin
         if (row.ms == '0 || (row.tone && row.half == '0)) begin
            nxt_state = '0;
         end else begin
            nxt_state.segment_is_tone    = row.tone;
            nxt_state.segment_ticks_left = SEG_TICKS_W'(row.ms * TICKS_PER_MS);
            nxt_state.half_period        = row.tone ? row.half : '0;
            nxt_state.half_ticks_left    = row.tone ? row.half : '0;
            nxt_state.wave_level         = row.tone;
         end
      end
   end

endmodule
